### hw/rtl/kst_pkg.sv
// Package for the key id slot table: request and status codes, field widths,
// and the structs passed along the cell chain. It depends on nothing.
package kst_pkg;

  localparam int unsigned ID_W        = 8;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned ACTIVE_W    = 5;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned STATUS_W    = 2;
  // Slot index width; covers tables of up to 256 slots.
  localparam int unsigned SLOT_IDX_W  = 8;
  localparam int unsigned SLOTS_DEFAULT = 16;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(16);

  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // Search token that walks the chain, one cell per cycle.
  typedef struct packed {
    logic                  valid;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] hit_idx;
    logic                  free;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic [KEY_W-1:0]      key_high;
    logic [KEY_W-1:0]      key_low;
  } tok_t;

  // Slot write broadcast to all cells; only the addressed cell takes it.
  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] idx;
    logic [ID_W-1:0]       id;
    logic [KEY_W-1:0]      key_high;
    logic [KEY_W-1:0]      key_low;
  } wr_t;

endpackage

### hw/rtl/kst_cell.sv
// One slot of the key id slot table: holds an id and a 128-bit key, updates
// the passing search token and registers it for the next cell. Uses kst_pkg.
module kst_cell
  import kst_pkg::*;
#(
  parameter int unsigned CellIdx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ID_W-1:0]     id_i,
  input  logic [ACTIVE_W-1:0] active_i,
  input  tok_t                tok_i,
  output tok_t                tok_o,
  input  wr_t                 wr_i
);

  localparam logic [SLOT_IDX_W-1:0] MyIdx = SLOT_IDX_W'(CellIdx);

  logic [ID_W-1:0]  id_q;
  logic [KEY_W-1:0] key_high_q;
  logic [KEY_W-1:0] key_low_q;
  logic             tok_valid_q;
  tok_t             tok_d;
  tok_t             tok_q;
  logic             in_range;
  logic             match;
  logic             is_free;
  logic             wr_me;

  assign in_range = MyIdx < SLOT_IDX_W'(active_i);
  assign match    = in_range && (id_i != '0) && (id_q == id_i);
  assign is_free  = in_range && (id_q == '0);
  assign wr_me    = wr_i.en && (wr_i.idx == MyIdx);

  // Record the first match and the first free slot seen so far.
  always_comb begin
    tok_d = tok_i;
    if (!tok_i.hit && match) begin
      tok_d.hit      = 1'b1;
      tok_d.hit_idx  = MyIdx;
      tok_d.key_high = key_high_q;
      tok_d.key_low  = key_low_q;
    end
    if (!tok_i.free && is_free) begin
      tok_d.free     = 1'b1;
      tok_d.free_idx = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q        <= '0;
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
      if (wr_me) begin
        id_q <= wr_i.id;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (wr_me) begin
      key_high_q <= wr_i.key_high;
      key_low_q  <= wr_i.key_low;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_valid_q;
  end

endmodule

### hw/rtl/key_id_slot_table.sv
// Key id slot table: SLOTS slots, each pairing an 8-bit key id (zero marks a
// free slot) with a 128-bit key. A request is a lookup, add or remove; each
// request beat gives exactly one result beat. Only slots below active_slots
// take part (a count above SLOTS acts as SLOTS). A lookup returns the key of
// the lowest matching slot; an add fills the lowest free slot unless the id is
// already present, and reports full whenever no free slot exists; a remove
// clears the lowest matching slot. An add or remove of id zero writes nothing.
// The slots form a chain of cells and a search token walks it one cell per
// cycle. A request passes through a registered token launch, the walk along
// every cell of the chain, a step that resolves the result and writes the
// slot, and the load of the output register once it is free or drains.
// A new request is taken once the previous result sits in the output register,
// so the next search overlaps the wait for the result to be taken. The
// active_slots register is written through the cfg channel, which is always
// ready; write it only while no request is in flight. Depends on kst_pkg and
// kst_cell.
module key_id_slot_table
  import kst_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [ACTIVE_W-1:0] cfg_active_slots_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [ID_W-1:0]     key_id_i,
  input  logic [KEY_W-1:0]    key_high_in_i,
  input  logic [KEY_W-1:0]    key_low_in_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic                found_o,
  output logic [KEY_W-1:0]    key_high_out_o,
  output logic [KEY_W-1:0]    key_low_out_o
);

  // Configuration register
  logic [ACTIVE_W-1:0] active_q;

  // Request held for the whole search
  logic                busy_q;
  logic                start_q;
  logic [REQ_W-1:0]    req_q;
  logic [ID_W-1:0]     id_q;
  logic [KEY_W-1:0]    key_high_q;
  logic [KEY_W-1:0]    key_low_q;

  // Resolved result waiting for the output register
  logic                res_valid_q;
  logic [STATUS_W-1:0] res_status_q;
  logic                res_found_q;
  logic [KEY_W-1:0]    res_key_high_q;
  logic [KEY_W-1:0]    res_key_low_q;

  logic [STATUS_W-1:0] res_status_d;
  logic                res_found_d;
  logic [KEY_W-1:0]    res_key_high_d;
  logic [KEY_W-1:0]    res_key_low_d;

  // Output register
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic                found_q;
  logic [KEY_W-1:0]    key_high_out_q;
  logic [KEY_W-1:0]    key_low_out_q;

  logic                in_beat;
  logic                out_load;
  tok_t                tok [SLOTS+1];
  tok_t                tok_last;
  wr_t                 wr;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !busy_q;
  assign in_beat     = in_valid_i && in_ready_o;
  // Move the resolved result on once the output register is free or drains.
  assign out_load    = res_valid_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RESET;
    end else if (cfg_valid_i) begin
      active_q <= cfg_active_slots_i;
    end
  end

  // Control: busy from the request beat until the result reaches the
  // output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= in_beat;
      if (in_beat) begin
        busy_q <= 1'b1;
      end else if (out_load) begin
        busy_q <= 1'b0;
      end
      if (tok_last.valid) begin
        res_valid_q <= 1'b1;
      end else if (out_load) begin
        res_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      req_q      <= req_type_i;
      id_q       <= key_id_i;
      key_high_q <= key_high_in_i;
      key_low_q  <= key_low_in_i;
    end
    if (tok_last.valid) begin
      res_status_q   <= res_status_d;
      res_found_q    <= res_found_d;
      res_key_high_q <= res_key_high_d;
      res_key_low_q  <= res_key_low_d;
    end
    if (out_load) begin
      status_q       <= res_status_q;
      found_q        <= res_found_q;
      key_high_out_q <= res_key_high_q;
      key_low_out_q  <= res_key_low_q;
    end
  end

  // Launch a fresh token into the first cell in the cycle after the request
  // beat, once the id is held steady for the compares.
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = start_q;
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    kst_cell #(
      .CellIdx(i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .id_i    (id_q),
      .active_i(active_q),
      .tok_i   (tok[i]),
      .tok_o   (tok[i+1]),
      .wr_i    (wr)
    );
  end

  assign tok_last = tok[SLOTS];

  // Resolve the walked token: result fields and the one slot write, if any.
  // The write lands at the same edge the result is captured.
  always_comb begin
    res_status_d   = ST_OK;
    res_found_d    = 1'b0;
    res_key_high_d = '0;
    res_key_low_d  = '0;
    wr             = '0;
    case (req_q)
      REQ_LOOKUP: begin
        res_found_d = tok_last.hit;
        if (tok_last.hit) begin
          res_key_high_d = tok_last.key_high;
          res_key_low_d  = tok_last.key_low;
        end else begin
          res_status_d = ST_MISS;
        end
      end
      REQ_ADD: begin
        res_found_d = tok_last.hit;
        if (!tok_last.free) begin
          res_status_d = ST_FULL;
        end else if (!tok_last.hit && (id_q != '0)) begin
          wr.en       = tok_last.valid;
          wr.idx      = tok_last.free_idx;
          wr.id       = id_q;
          wr.key_high = key_high_q;
          wr.key_low  = key_low_q;
        end
      end
      REQ_REMOVE: begin
        res_found_d = tok_last.hit;
        if (tok_last.hit) begin
          // clear id and key of the lowest matching slot
          wr.en  = tok_last.valid;
          wr.idx = tok_last.hit_idx;
        end
      end
      default: begin
        // no operation: ok, nothing found, zero key
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign found_o        = found_q;
  assign key_high_out_o = key_high_out_q;
  assign key_low_out_o  = key_low_out_q;

endmodule

### bench/key_id_slot_table_test.sv
// Testbench for the key id slot table: directed and random lookup, add,
// remove and no-op beats with random idling on both channels, checked against
// a model. Depends on kst_pkg and the key_id_slot_table RTL.
`timescale 1ns / 1ps

module key_id_slot_table_test;
  import kst_pkg::*;

  // Table size under test and the request-to-result latency it implies.
  localparam int unsigned TABLE_SLOTS = SLOTS_DEFAULT;
  localparam int unsigned LATENCY     = TABLE_SLOTS + 3;
  // Quiet cycles before the watchdog gives up; far above any legal stall.
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SEG_ITEMS   = 159;
  localparam int unsigned PRINT_LIMIT = 20;

  // The package has no name for the unused request code: a no-op.
  localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;

  typedef enum logic [1:0] {
    STIM_REQ,   // one request beat
    STIM_CFG,   // drain, then write active_slots and switch idling
    STIM_DRAIN  // drain, then switch idling
  } stim_kind_e;

  typedef struct {
    stim_kind_e          kind;
    logic [REQ_W-1:0]    req;
    logic [ID_W-1:0]     id;
    logic [KEY_W-1:0]    key_hi;
    logic [KEY_W-1:0]    key_lo;
    logic [ACTIVE_W-1:0] active;
    int unsigned         send_idle;
    int unsigned         recv_idle;
  } stim_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [KEY_W-1:0]    key_hi;
    logic [KEY_W-1:0]    key_lo;
  } reply_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [ACTIVE_W-1:0] cfg_active_slots_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [REQ_W-1:0]    req_type_i;
  logic [ID_W-1:0]     key_id_i;
  logic [KEY_W-1:0]    key_high_in_i;
  logic [KEY_W-1:0]    key_low_in_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [STATUS_W-1:0] status_o;
  logic                found_o;
  logic [KEY_W-1:0]    key_high_out_o;
  logic [KEY_W-1:0]    key_low_out_o;

  key_id_slot_table #(
    .SLOTS(TABLE_SLOTS)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_active_slots_i(cfg_active_slots_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .key_id_i          (key_id_i),
    .key_high_in_i     (key_high_in_i),
    .key_low_in_i      (key_low_in_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .found_o           (found_o),
    .key_high_out_o    (key_high_out_o),
    .key_low_out_o     (key_low_out_o)
  );

  // Beats still to drive, and replies the table owes us, oldest first.
  stim_t       pending_beats[$];
  reply_t      owed_replies[$];

  // Our own copy of the table and its active count.
  logic [ID_W-1:0]     model_id    [TABLE_SLOTS];
  logic [KEY_W-1:0]    model_key_hi[TABLE_SLOTS];
  logic [KEY_W-1:0]    model_key_lo[TABLE_SLOTS];
  logic [ACTIVE_W-1:0] model_active;

  int unsigned requests_sent;   // written by the driver only
  int unsigned replies_taken;   // written by the monitor only
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned quiet_cycles;
  int unsigned mismatches;
  int unsigned cfg_writes;
  int unsigned lookup_hits, lookup_misses, adds_stored, adds_full, removes_hit;

  // Apply one request to the table copy and return the reply it must produce.
  // The lowest active slot wins both the id match and the free-slot pick.
  function automatic reply_t apply_table_request(input logic [REQ_W-1:0] req,
                                                 input logic [ID_W-1:0]  id,
                                                 input logic [KEY_W-1:0] key_hi,
                                                 input logic [KEY_W-1:0] key_lo);
    reply_t r;
    int     live;
    int     hit;
    int     free_slot;
    int     i;
    r         = '0;
    r.status  = ST_OK;
    // A count above the table size acts as the full table.
    live      = (model_active > TABLE_SLOTS) ? int'(TABLE_SLOTS) : int'(model_active);
    hit       = -1;
    free_slot = -1;
    // Walk downward so the last assignment is the lowest slot.
    for (i = live - 1; i >= 0; i--) begin
      // A free slot never matches, so id zero can never hit.
      if (id != '0 && model_id[i] == id) hit = i;
      if (model_id[i] == '0) free_slot = i;
    end
    case (req)
      REQ_LOOKUP: begin
        if (hit >= 0) begin
          r.found  = 1'b1;
          r.key_hi = model_key_hi[hit];
          r.key_lo = model_key_lo[hit];
          lookup_hits++;
        end else begin
          r.status = ST_MISS;
          lookup_misses++;
        end
      end
      REQ_ADD: begin
        r.found = (hit >= 0);
        // Full wins even when the id is already present.
        if (free_slot < 0) begin
          r.status = ST_FULL;
          adds_full++;
        end else if (hit < 0 && id != '0) begin
          model_id[free_slot]     = id;
          model_key_hi[free_slot] = key_hi;
          model_key_lo[free_slot] = key_lo;
          adds_stored++;
        end
      end
      REQ_REMOVE: begin
        if (hit >= 0) begin
          r.found           = 1'b1;
          model_id[hit]     = '0;
          model_key_hi[hit] = '0;
          model_key_lo[hit] = '0;
          removes_hit++;
        end
      end
      default: ;  // no-op: all-zero reply with status ok
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [127:0] got,
                                 input logic [127:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("%0t: mismatch in %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void queue_request(input logic [REQ_W-1:0] req,
                                        input logic [ID_W-1:0]  id,
                                        input logic [KEY_W-1:0] key_hi,
                                        input logic [KEY_W-1:0] key_lo);
    stim_t s;
    s        = '{kind: STIM_REQ, default: '0};
    s.req    = req;
    s.id     = id;
    s.key_hi = key_hi;
    s.key_lo = key_lo;
    pending_beats.push_back(s);
  endfunction

  // A marker waits for the table to drain; a config marker then writes it.
  function automatic void queue_marker(input stim_kind_e kind,
                                       input logic [ACTIVE_W-1:0] active,
                                       input int unsigned s_idle,
                                       input int unsigned r_idle);
    stim_t s;
    s           = '{kind: STIM_DRAIN, default: '0};
    s.kind      = kind;
    s.active    = active;
    s.send_idle = s_idle;
    s.recv_idle = r_idle;
    pending_beats.push_back(s);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Driver: count the accepted beat, feed the model, then line up the next
  // one. Hold valid and payload while a beat waits for ready.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    stim_t       cur;
    int unsigned sent_now;
    logic        drive_req;
    logic        drive_cfg;
    int          r;
    if (!rst_ni) begin
      in_valid_i         <= 1'b0;
      cfg_valid_i        <= 1'b0;
      cfg_active_slots_i <= '0;
      req_type_i         <= REQ_LOOKUP;
      key_id_i           <= '0;
      key_high_in_i      <= '0;
      key_low_in_i       <= '0;
      requests_sent      <= 0;
      send_idle          <= 19;
      recv_idle          <= 76;
      for (r = 0; r < TABLE_SLOTS; r++) begin
        model_id[r]     = '0;
        model_key_hi[r] = '0;
        model_key_lo[r] = '0;
      end
      model_active = ACTIVE_RESET;
    end else begin
      sent_now = requests_sent;
      if (in_valid_i && in_ready_o) begin
        owed_replies.push_back(apply_table_request(req_type_i, key_id_i,
                                                   key_high_in_i, key_low_in_i));
        sent_now++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        model_active = cfg_active_slots_i;
        cfg_writes++;
      end
      requests_sent <= sent_now;

      // Only move on once nothing is waiting for ready.
      if (!(in_valid_i && !in_ready_o) && !(cfg_valid_i && !cfg_ready_o)) begin
        drive_req = 1'b0;
        drive_cfg = 1'b0;
        if (pending_beats.size() != 0) begin
          if (pending_beats[0].kind == STIM_REQ) begin
            if ($urandom_range(99) >= send_idle) begin
              cur           = pending_beats.pop_front();
              drive_req     = 1'b1;
              req_type_i    <= cur.req;
              key_id_i      <= cur.id;
              key_high_in_i <= cur.key_hi;
              key_low_in_i  <= cur.key_lo;
            end
          end else if (sent_now == replies_taken) begin
            // Every reply is in: the table is idle, safe to reconfigure.
            cur = pending_beats.pop_front();
            if (cur.kind == STIM_CFG) begin
              drive_cfg          = 1'b1;
              cfg_active_slots_i <= cur.active;
            end
            send_idle <= cur.send_idle;
            recv_idle <= cur.recv_idle;
          end
        end
        in_valid_i  <= drive_req;
        cfg_valid_i <= drive_cfg;
      end
    end
  end

  // Monitor: check each result beat against the oldest owed reply, and
  // stall the result channel at random.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    reply_t want;
    if (!rst_ni) begin
      out_ready_i   <= 1'b0;
      replies_taken <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        replies_taken <= replies_taken + 1;
        if (owed_replies.size() == 0) begin
          report_mismatch("unexpected result", 128'({status_o, found_o}),
                          128'd0);
        end else begin
          want = owed_replies.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", 128'(status_o), 128'(want.status));
          if (found_o !== want.found)
            report_mismatch("found", 128'(found_o), 128'(want.found));
          if (key_high_out_o !== want.key_hi)
            report_mismatch("key_high_out", 128'(key_high_out_o), 128'(want.key_hi));
          if (key_low_out_o !== want.key_lo)
            report_mismatch("key_low_out", 128'(key_low_out_o), 128'(want.key_lo));
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog: any accepted beat on any channel resets the quiet count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ACTIVE_W-1:0] seg_active[9];
    logic [REQ_W-1:0]    req;
    logic [ID_W-1:0]     id;
    int unsigned         seg;
    int unsigned         n;
    int unsigned         pick;
    int unsigned         s_idle;
    int unsigned         r_idle;

    // Drive every input known before the first edge; hold reset.
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    cfg_valid_i        = 1'b0;
    out_ready_i        = 1'b0;
    cfg_active_slots_i = '0;
    req_type_i         = REQ_LOOKUP;
    key_id_i           = '0;
    key_high_in_i      = '0;
    key_low_in_i       = '0;
    quiet_cycles       = 0;
    mismatches         = 0;
    cfg_writes         = 0;
    lookup_hits        = 0;
    lookup_misses      = 0;
    adds_stored        = 0;
    adds_full          = 0;
    removes_hit        = 0;

    // Directed beats at the reset size of sixteen slots.
    queue_marker(STIM_DRAIN, '0, 19, 76);
    queue_request(REQ_LOOKUP, 8'd0, '0, '0);           // id zero never hits
    queue_request(REQ_REMOVE, 8'd0, '0, '0);           // remove of id zero
    queue_request(REQ_ADD, 8'd0, '1, '1);              // add of id zero: no write
    queue_request(REQ_ADD, 8'hFF, '1, '1);
    queue_request(REQ_ADD, 8'd1, '0, '0);
    queue_request(REQ_LOOKUP, 8'hFF, '0, '0);
    queue_request(REQ_ADD, 8'hFF, {16{4'h5}}, {16{4'hA}}); // present: no write
    queue_request(REQ_NOP, 8'hFF, '1, '1);
    queue_request(REQ_LOOKUP, 8'd1, '1, '1);
    queue_request(REQ_REMOVE, 8'hFF, '1, '1);
    queue_request(REQ_LOOKUP, 8'hFF, '0, '0);
    queue_request(REQ_REMOVE, 8'hFF, '0, '0);           // remove of an absent id
    queue_request(REQ_ADD, 8'h80, {16{4'hA}}, {16{4'h5}});
    // Shrink to two slots, both taken: adds report full until a remove frees one.
    queue_marker(STIM_CFG, 5'd2, 19, 76);
    queue_request(REQ_ADD, 8'd10, '1, '0);
    queue_request(REQ_ADD, 8'd1, '1, '0);              // full even though present
    queue_request(REQ_ADD, 8'd0, '1, '0);
    queue_request(REQ_REMOVE, 8'd1, '0, '0);
    queue_request(REQ_ADD, 8'd10, {2{32'hDEAD_BEEF}}, {2{32'h0123_4567}});
    queue_request(REQ_LOOKUP, 8'd10, '0, '0);

    // Random segments over several table sizes, the extremes among them:
    // zero searches nothing, 31 acts as the full table.
    seg_active = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd2, 5'd9, 5'd16, 5'd13};
    for (seg = 0; seg < 9; seg++) begin
      // Three idling phases: sender light, then receiver light, then none.
      case (seg / 3)
        0:       begin s_idle = 19; r_idle = 76; end
        1:       begin s_idle = 76; r_idle = 19; end
        default: begin s_idle = 0;  r_idle = 0;  end
      endcase
      queue_marker(STIM_CFG, seg_active[seg], s_idle, r_idle);
      for (n = 0; n < SEG_ITEMS; n++) begin
        // Halfway through, pause the sender until every reply is back.
        if (n == SEG_ITEMS / 2) queue_marker(STIM_DRAIN, '0, s_idle, r_idle);
        // Mostly a small id pool so adds, hits, removes and full all recur.
        pick = $urandom_range(99);
        if (pick < 5)       id = 8'd0;
        else if (pick < 15) id = 8'($urandom_range(255));
        else if (pick < 18) id = 8'hFF;
        else                id = 8'($urandom_range(24, 1));
        pick = $urandom_range(99);
        if (pick < 36)      req = REQ_ADD;
        else if (pick < 70) req = REQ_LOOKUP;
        else if (pick < 95) req = REQ_REMOVE;
        else                req = REQ_NOP;
        queue_request(req, id, {$urandom, $urandom}, {$urandom, $urandom});
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all beats to go out and every reply to come back.
    while (pending_beats.size() != 0 || in_valid_i || cfg_valid_i ||
           replies_taken != requests_sent)
      @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);

    if (owed_replies.size() != 0)
      report_mismatch("replies never delivered", 128'd0, 128'(owed_replies.size()));

    $display("covered %0d requests, %0d config writes: %0d lookup hits, %0d misses,",
             requests_sent, cfg_writes, lookup_hits, lookup_misses);
    $display("  %0d adds stored, %0d adds refused full, %0d removes that hit",
             adds_stored, adds_full, removes_hit);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### key_id_slot_table.f
hw/rtl/kst_pkg.sv
hw/rtl/kst_cell.sv
hw/rtl/key_id_slot_table.sv
bench/key_id_slot_table_test.sv
